>>> rtl/xsa_pkg.sv
// shared constants, field widths and lane/grant types for the switch allocator
// no dependencies; imported by every module of the block
`default_nettype none

package xsa_pkg;

  // router geometry
  localparam int PORT_COUNT     = 4;
  localparam int NUM_VNS        = 2;
  localparam int NUM_VCS        = 2;
  localparam int SLOTS_PER_PORT = NUM_VNS * NUM_VCS;
  localparam int NUM_SLOTS      = PORT_COUNT * SLOTS_PER_PORT;

  // index widths
  localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int VN_W   = (NUM_VNS > 1) ? $clog2(NUM_VNS) : 1;
  localparam int VC_W   = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
  localparam int SPP_W  = (SLOTS_PER_PORT > 1) ? $clog2(SLOTS_PER_PORT) : 1;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // fixed field widths of the word layout
  localparam int MASK_W      = 4;
  localparam int REQ_W       = 16;
  localparam int DEST_W      = 2;
  localparam int DESTS_W     = 32;
  localparam int GRANT_SRC_W = 2;
  localparam int SRC_W       = 8;
  localparam int MATCH_W     = (PORT_W > DEST_W) ? PORT_W : DEST_W;

  localparam logic [MASK_W-1:0] PRESENT_RESET = 4'hF;

  // what one sender lane found for the current receive port
  typedef struct packed {
    logic             hit;
    logic [VN_W-1:0]  vn;
    logic [VC_W-1:0]  vc;
    logic             dvc;
    logic [SPP_W-1:0] slot;
  } lane_hit_t;

  // merged winner over all sender lanes
  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] src;
    logic [VN_W-1:0]   vn;
    logic [VC_W-1:0]   vc;
    logic              dvc;
    logic [SPP_W-1:0]  slot;
  } grant_t;

endpackage

`default_nettype wire

>>> rtl/crossbar_round_robin_switch_allocator.sv
// top level of the round-robin crossbar switch allocator
// depends on xsa_pkg, xsa_lane and xsa_merge
`default_nettype none

// One input word is one allocation round. The round visits one receive port
// per cycle, starting at the receive pointer; all sender lanes search in
// parallel in that cycle and the merge stage picks the winner from the send
// pointer. A new word is taken while idle, or in the same cycle that the
// previous result moves into the output register; no new word is taken
// while a round is still in progress. The port_present_mask register resets
// to all ports present and is written through cfg_wr_en / cfg_wr_data.
module crossbar_round_robin_switch_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [xsa_pkg::MASK_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [xsa_pkg::MASK_W-1:0]   in_recv_busy_mask,
  input  logic [xsa_pkg::MASK_W-1:0]   in_send_busy_mask,
  input  logic [xsa_pkg::REQ_W-1:0]    in_request_valid_mask,
  input  logic [xsa_pkg::DESTS_W-1:0]  in_request_dest_ports,
  input  logic [xsa_pkg::REQ_W-1:0]    in_dest_vc_map,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [xsa_pkg::MASK_W-1:0]   out_grant_valid_mask,
  output logic [xsa_pkg::SRC_W-1:0]    out_grant_source_ports,
  output logic [xsa_pkg::MASK_W-1:0]   out_grant_vns,
  output logic [xsa_pkg::MASK_W-1:0]   out_grant_source_vcs,
  output logic [xsa_pkg::MASK_W-1:0]   out_grant_dest_vcs,
  output logic [xsa_pkg::MASK_W-1:0]   out_send_granted_mask,
  output logic [xsa_pkg::REQ_W-1:0]    out_cleared_request_mask
);
  import xsa_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t state_r, state_nxt;

  logic [MASK_W-1:0]  present_r;
  logic [PORT_W-1:0]  recv_ptr_r, send_ptr_r;
  logic [VN_W-1:0]    vn_ptr_r;
  logic [VC_W-1:0]    vc_ptr_r;
  logic [PORT_W-1:0]  cur_port_r, step_r;
  logic               out_valid_r;

  // captured input word
  logic [MASK_W-1:0]  rbusy_r, sbusy_r;
  logic [REQ_W-1:0]   rvalid_r, rdvc_r;
  logic [DESTS_W-1:0] rdest_r;

  // round accumulators
  logic [PORT_COUNT-1:0]             taken_r;
  logic [PORT_COUNT-1:0]             gv_r;
  logic [PORT_COUNT-1:0][PORT_W-1:0] gsrc_r;
  logic [PORT_COUNT-1:0][VN_W-1:0]   gvn_r;
  logic [PORT_COUNT-1:0][VC_W-1:0]   gsvc_r;
  logic [PORT_COUNT-1:0]             gdvc_r;
  logic [PORT_COUNT-1:0]             sg_r;
  logic [NUM_SLOTS-1:0]              clr_r;

  // output registers
  logic [MASK_W-1:0] o_gv_r, o_gvn_r, o_gsvc_r, o_gdvc_r, o_sg_r;
  logic [SRC_W-1:0]  o_gsrc_r;
  logic [REQ_W-1:0]  o_clr_r;

  // per-port views of the masks
  logic [PORT_COUNT-1:0] present_v, rbusy_v, sbusy_v, eligible;
  logic [PORT_COUNT-1:0][SLOTS_PER_PORT-1:0]             lane_valid, lane_dvc;
  logic [PORT_COUNT-1:0][SLOTS_PER_PORT-1:0][DEST_W-1:0] lane_dest;
  lane_hit_t [PORT_COUNT-1:0] lane_hits;
  grant_t                     grant;

  // packed result word
  logic [MASK_W-1:0] pk_gv, pk_gvn, pk_gsvc, pk_gdvc, pk_sg;
  logic [SRC_W-1:0]  pk_gsrc;
  logic [REQ_W-1:0]  pk_clr;

  logic              accept, last_step, out_free, load_out, recv_ok, do_grant;
  logic [SLOT_W-1:0] slot_idx;

  // mask bits past the field width read as absent / idle / no request
  for (genvar P = 0; P < PORT_COUNT; P++) begin : g_port
    if (P < MASK_W) begin : g_in
      assign present_v[P] = present_r[P];
      assign rbusy_v[P]   = rbusy_r[P];
      assign sbusy_v[P]   = sbusy_r[P];
    end else begin : g_out
      assign present_v[P] = 1'b0;
      assign rbusy_v[P]   = 1'b0;
      assign sbusy_v[P]   = 1'b0;
    end
    assign eligible[P] = present_v[P] & ~sbusy_v[P] & ~taken_r[P];

    for (genvar K = 0; K < SLOTS_PER_PORT; K++) begin : g_slot
      localparam int S = P * SLOTS_PER_PORT + K;
      if (S < REQ_W) begin : g_vin
        assign lane_valid[P][K] = rvalid_r[S];
        assign lane_dvc[P][K]   = rdvc_r[S];
      end else begin : g_vout
        assign lane_valid[P][K] = 1'b0;
        assign lane_dvc[P][K]   = 1'b0;
      end
      if (DEST_W * S + DEST_W <= DESTS_W) begin : g_din
        assign lane_dest[P][K] = rdest_r[DEST_W*S +: DEST_W];
      end else begin : g_dout
        assign lane_dest[P][K] = '0;
      end
    end

    xsa_lane u_lane (
      .eligible  (eligible[P]),
      .req_valid (lane_valid[P]),
      .req_dest  (lane_dest[P]),
      .req_dvc   (lane_dvc[P]),
      .recv_port (cur_port_r),
      .vn_ptr    (vn_ptr_r),
      .vc_ptr    (vc_ptr_r),
      .hit       (lane_hits[P])
    );
  end

  xsa_merge u_merge (
    .lanes    (lane_hits),
    .send_ptr (send_ptr_r),
    .grant    (grant)
  );

  // handshake and step control
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || ((state_r == ST_DONE) && out_free));
  assign accept    = in_valid && !in_stall;
  assign load_out  = (state_r == ST_DONE) && out_free;
  assign last_step = (step_r == PORT_W'(PORT_COUNT - 1));
  assign recv_ok   = present_v[cur_port_r] & ~rbusy_v[cur_port_r];
  assign do_grant  = (state_r == ST_RUN) && recv_ok && grant.hit;
  assign slot_idx  = SLOT_W'(grant.src) * SLOT_W'(SLOTS_PER_PORT) + SLOT_W'(grant.slot);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (last_step) state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = accept ? ST_RUN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // pack per-port results into the output field layout
  for (genvar R = 0; R < MASK_W; R++) begin : g_pack
    if (R < PORT_COUNT) begin : g_in
      assign pk_gv[R]   = gv_r[R];
      assign pk_gvn[R]  = gvn_r[R][0];
      assign pk_gsvc[R] = gsvc_r[R][0];
      assign pk_gdvc[R] = gdvc_r[R];
      assign pk_sg[R]   = sg_r[R];
      assign pk_gsrc[R*GRANT_SRC_W +: GRANT_SRC_W] = GRANT_SRC_W'(gsrc_r[R]);
    end else begin : g_out
      assign pk_gv[R]   = 1'b0;
      assign pk_gvn[R]  = 1'b0;
      assign pk_gsvc[R] = 1'b0;
      assign pk_gdvc[R] = 1'b0;
      assign pk_sg[R]   = 1'b0;
      assign pk_gsrc[R*GRANT_SRC_W +: GRANT_SRC_W] = '0;
    end
  end

  for (genvar S = 0; S < REQ_W; S++) begin : g_clr
    if (S < NUM_SLOTS) begin : g_in
      assign pk_clr[S] = clr_r[S];
    end else begin : g_out
      assign pk_clr[S] = 1'b0;
    end
  end

  // state, pointers, config register and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      present_r   <= PRESENT_RESET;
      recv_ptr_r  <= '0;
      send_ptr_r  <= '0;
      vn_ptr_r    <= '0;
      vc_ptr_r    <= '0;
      cur_port_r  <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) present_r <= cfg_wr_data;

      if (accept) begin
        cur_port_r <= recv_ptr_r;
        step_r     <= '0;
      end else if (state_r == ST_RUN) begin
        cur_port_r <= (cur_port_r == PORT_W'(PORT_COUNT - 1)) ? '0 : cur_port_r + 1'b1;
        step_r     <= step_r + 1'b1;
      end

      // all pointers move once per round
      if ((state_r == ST_RUN) && last_step) begin
        recv_ptr_r <= (recv_ptr_r == PORT_W'(PORT_COUNT - 1)) ? '0 : recv_ptr_r + 1'b1;
        send_ptr_r <= (send_ptr_r == PORT_W'(PORT_COUNT - 1)) ? '0 : send_ptr_r + 1'b1;
        vn_ptr_r   <= (vn_ptr_r == VN_W'(NUM_VNS - 1)) ? '0 : vn_ptr_r + 1'b1;
        vc_ptr_r   <= (vc_ptr_r == VC_W'(NUM_VCS - 1)) ? '0 : vc_ptr_r + 1'b1;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
        o_gv_r      <= pk_gv;
        o_gsrc_r    <= pk_gsrc;
        o_gvn_r     <= pk_gvn;
        o_gsvc_r    <= pk_gsvc;
        o_gdvc_r    <= pk_gdvc;
        o_sg_r      <= pk_sg;
        o_clr_r     <= pk_clr;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input capture and per-round accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      rbusy_r  <= in_recv_busy_mask;
      sbusy_r  <= in_send_busy_mask;
      rvalid_r <= in_request_valid_mask;
      rdest_r  <= in_request_dest_ports;
      rdvc_r   <= in_dest_vc_map;
      taken_r  <= '0;
      gv_r     <= '0;
      gsrc_r   <= '0;
      gvn_r    <= '0;
      gsvc_r   <= '0;
      gdvc_r   <= '0;
      sg_r     <= '0;
      clr_r    <= '0;
    end else if (do_grant) begin
      taken_r[grant.src]  <= 1'b1;
      sg_r[grant.src]     <= 1'b1;
      clr_r[slot_idx]     <= 1'b1;
      gv_r[cur_port_r]    <= 1'b1;
      gsrc_r[cur_port_r]  <= grant.src;
      gvn_r[cur_port_r]   <= grant.vn;
      gsvc_r[cur_port_r]  <= grant.vc;
      gdvc_r[cur_port_r]  <= grant.dvc;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_grant_valid_mask     = o_gv_r;
  assign out_grant_source_ports   = o_gsrc_r;
  assign out_grant_vns            = o_gvn_r;
  assign out_grant_source_vcs     = o_gsvc_r;
  assign out_grant_dest_vcs       = o_gdvc_r;
  assign out_send_granted_mask    = o_sg_r;
  assign out_cleared_request_mask = o_clr_r;

`ifndef SYNTHESIS
  // a sender that came in busy is never marked as taken
  a_taken_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((taken_r & sbusy_v) == '0))
    else $error("busy sender was granted");

  // a round ends in ST_DONE after its last receive port step
  a_round_length: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && last_step) |=> (state_r == ST_DONE))
    else $error("round did not end after last receive port");

  // grants only go to present receive ports
  a_grant_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_grant_valid_mask & ~present_r) == '0))
    else $error("grant to an absent receive port");
`endif

endmodule

`default_nettype wire

>>> rtl/xsa_lane.sv
// one sender lane: scans this sender's vn/vc slots round-robin for a request
// aimed at the current receive port; uses xsa_pkg
`default_nettype none

module xsa_lane (
  input  logic                                                    eligible,
  input  logic [xsa_pkg::SLOTS_PER_PORT-1:0]                      req_valid,
  input  logic [xsa_pkg::SLOTS_PER_PORT-1:0][xsa_pkg::DEST_W-1:0] req_dest,
  input  logic [xsa_pkg::SLOTS_PER_PORT-1:0]                      req_dvc,
  input  logic [xsa_pkg::PORT_W-1:0]                              recv_port,
  input  logic [xsa_pkg::VN_W-1:0]                                vn_ptr,
  input  logic [xsa_pkg::VC_W-1:0]                                vc_ptr,
  output xsa_pkg::lane_hit_t                                      hit
);
  import xsa_pkg::*;

  lane_hit_t hit_c;

  // vn outer, vc inner, both starting at their pointers; first match wins
  always_comb begin
    int               vn_i;
    int               vc_i;
    int               k_i;
    logic [MATCH_W-1:0] want;
    hit_c = '0;
    want  = MATCH_W'(recv_port);
    for (int a = 0; a < NUM_VNS; a++) begin
      vn_i = int'(vn_ptr) + a;
      if (vn_i >= NUM_VNS) vn_i = vn_i - NUM_VNS;
      for (int b = 0; b < NUM_VCS; b++) begin
        vc_i = int'(vc_ptr) + b;
        if (vc_i >= NUM_VCS) vc_i = vc_i - NUM_VCS;
        k_i = vn_i * NUM_VCS + vc_i;
        if (eligible && !hit_c.hit && req_valid[SPP_W'(k_i)] &&
            (MATCH_W'(req_dest[SPP_W'(k_i)]) == want)) begin
          hit_c.hit  = 1'b1;
          hit_c.vn   = VN_W'(vn_i);
          hit_c.vc   = VC_W'(vc_i);
          hit_c.dvc  = req_dvc[SPP_W'(k_i)];
          hit_c.slot = SPP_W'(k_i);
        end
      end
    end
  end

  assign hit = hit_c;

endmodule

`default_nettype wire

>>> rtl/xsa_merge.sv
// merging stage: picks the first hitting sender lane from the send pointer
// uses xsa_pkg lane_hit_t and grant_t
`default_nettype none

module xsa_merge (
  input  xsa_pkg::lane_hit_t [xsa_pkg::PORT_COUNT-1:0] lanes,
  input  logic [xsa_pkg::PORT_W-1:0]                   send_ptr,
  output xsa_pkg::grant_t                              grant
);
  import xsa_pkg::*;

  grant_t grant_c;

  // round-robin priority over the sender lanes
  always_comb begin
    int p_i;
    grant_c = '0;
    for (int j = 0; j < PORT_COUNT; j++) begin
      p_i = int'(send_ptr) + j;
      if (p_i >= PORT_COUNT) p_i = p_i - PORT_COUNT;
      if (!grant_c.hit && lanes[PORT_W'(p_i)].hit) begin
        grant_c.hit  = 1'b1;
        grant_c.src  = PORT_W'(p_i);
        grant_c.vn   = lanes[PORT_W'(p_i)].vn;
        grant_c.vc   = lanes[PORT_W'(p_i)].vc;
        grant_c.dvc  = lanes[PORT_W'(p_i)].dvc;
        grant_c.slot = lanes[PORT_W'(p_i)].slot;
      end
    end
  end

  assign grant = grant_c;

endmodule

`default_nettype wire
